@@ rtl/n7s_pkg.sv @@
`timescale 1ns / 1ps
package n7s_pkg;

   localparam int MAX_DIGITS = 8;
   // places the chain holds: the position fields are 3 bits wide
   localparam int PLACE_CAP = (MAX_DIGITS < 8) ? MAX_DIGITS : 8;
   localparam int PLACE_W = 3;
   localparam int CODE_W = 5;

   typedef logic [CODE_W-1:0] code_type;

   localparam code_type CODE_ZERO  = 5'd0;
   localparam code_type CODE_MINUS = 5'd16;
   localparam code_type CODE_BLANK = 5'd17;

   // control shared by every cell of the character chain
   typedef struct packed {
      logic clear;
      logic push;
      logic pop;
   } chain_ctl_type;

   localparam logic [1:0] CSR_DIGIT_COUNT   = 2'd0;
   localparam logic [1:0] CSR_UNIT_LIMIT    = 2'd1;
   localparam logic [1:0] CSR_SEGMENT_ORDER = 2'd2;

   localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;

   function automatic logic [6:0] glyph(input code_type code);
      logic [6:0] seg;
      begin
         case (code)
            5'd0:    seg = 7'h7E;
            5'd1:    seg = 7'h30;
            5'd2:    seg = 7'h6D;
            5'd3:    seg = 7'h79;
            5'd4:    seg = 7'h33;
            5'd5:    seg = 7'h5B;
            5'd6:    seg = 7'h5F;
            5'd7:    seg = 7'h70;
            5'd8:    seg = 7'h7F;
            5'd9:    seg = 7'h7B;
            5'd10:   seg = 7'h77;
            5'd11:   seg = 7'h7F;
            5'd12:   seg = 7'h4E;
            5'd13:   seg = 7'h7E;
            5'd14:   seg = 7'h4F;
            5'd15:   seg = 7'h47;
            5'd16:   seg = 7'h01;
            default: seg = 7'h00;
         endcase
         glyph = seg;
      end
   endfunction

endpackage

@@ rtl/n7s_cell.sv @@
`timescale 1ns / 1ps
module n7s_cell (
   input  logic                   clock,
   input  n7s_pkg::chain_ctl_type ctl,
   input  n7s_pkg::code_type      lo_code,
   input  n7s_pkg::code_type      hi_code,
   output n7s_pkg::code_type      code
);

   n7s_pkg::code_type code_ff;
   n7s_pkg::code_type code_in;

   // push moves characters toward higher cells, pop toward cell 0
   always_comb begin
      code_in = code_ff;
      if (ctl.clear) begin
         code_in = n7s_pkg::CODE_BLANK;
      end else if (ctl.push) begin
         code_in = lo_code;
      end else if (ctl.pop) begin
         code_in = hi_code;
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
   end

   assign code = code_ff;

endmodule

@@ rtl/n7s_digit.sv @@
`timescale 1ns / 1ps
module n7s_digit (
   input  logic        hex,
   input  logic [31:0] mag,
   output logic [3:0]  digit,
   output logic [31:0] quot
);

   logic [63:0] prod;
   logic [31:0] q10;
   logic [31:0] dec_q;
   logic [31:0] dec_r;

   // divide by ten through the reciprocal, exact over all 32-bit values
   always_comb begin
      prod  = {32'd0, mag} * {32'd0, n7s_pkg::RECIP_TEN};
      dec_q = {3'd0, prod[63:35]};
      q10   = {dec_q[28:0], 3'd0} + {dec_q[30:0], 1'b0};
      dec_r = mag - q10;
      if (hex) begin
         digit = mag[3:0];
         quot  = {4'd0, mag[31:4]};
      end else begin
         digit = dec_r[3:0];
         quot  = dec_q;
      end
   end

endmodule

@@ rtl/number_to_seven_segment_formatter.sv @@
`timescale 1ns / 1ps
// Seven-segment formatter for a row of display modules.
// req_ carries one number with its radix, dot mask, leading-zero flag,
// right offset and module index. Each transaction addressed to a module
// below unit_limit yields digit_count transactions on rsp_, digit_count
// held to 1 to 8: one segment pattern per place, leftmost first, with
// rsp_last on place 0. A request to a module at or above unit_limit is
// taken and gives nothing. csr_ writes digit_count, unit_limit and
// segment_order; it is always ready. The user must see that it is
// written only while the block is idle; the block does not enforce it.
// A request is taken, then one character per cycle is formed by the
// digit unit (divide by ten, or shift by four in hex) and pushed into
// the character chain, then one pattern per cycle leaves through the
// output register while the receiver is ready. After the last
// conversion step the block moves to the emit state, and the first
// pattern is then loaded into the output register.
// Reset restores digit_count 8, unit_limit 1, segment_order 0 and empties
// the output. When rsp_ready is low the output register holds its pattern
// and the character chain waits; a new request is accepted once the last
// pattern of the previous one sits in the output register.
module number_to_seven_segment_formatter (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_number,
   input  logic        req_mode,
   input  logic [7:0]  req_dot_mask,
   input  logic        req_leading_zeros,
   input  logic [2:0]  req_right_offset,
   input  logic [2:0]  req_module_req,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_target_module,
   output logic [2:0]  rsp_digit_position,
   output logic [7:0]  rsp_segment_pattern,
   output logic        rsp_last,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [3:0]  csr_data
);

   localparam int PW = n7s_pkg::PLACE_W;
   localparam int NC = n7s_pkg::PLACE_CAP;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic [3:0]  digit_count_ff, unit_limit_ff;
   logic        segment_order_ff;

   logic [31:0] mag_ff, mag_in;
   logic        hex_ff, hex_in;
   logic        lz_ff, lz_in;
   logic        neg_ff, neg_in;
   logic        first_ff, first_in;
   logic        sign_done_ff, sign_done_in;
   logic [7:0]  dots_ff, dots_in;
   logic [2:0]  module_ff, module_in;
   logic [PW-1:0] step_ff, step_in;
   logic [PW-1:0] top_ff, top_in;
   logic [PW-1:0] place_ff, place_in;
   logic [PW-1:0] last_place_ff, last_place_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_module_ff, rsp_module_in;
   logic [2:0]  rsp_place_ff, rsp_place_in;
   logic [7:0]  rsp_pattern_ff, rsp_pattern_in;
   logic        rsp_last_ff, rsp_last_in;

   n7s_pkg::chain_ctl_type ctl;
   n7s_pkg::code_type      cell_code [NC];
   n7s_pkg::code_type      new_code;

   logic [3:0]  digit;
   logic [31:0] quot;
   logic        req_take;
   logic        emit_load;
   logic [3:0]  n_sat;
   logic [PW-1:0] n_m1;
   logic [PW-1:0] roff_sat;
   logic [6:0]  seg;

   n7s_digit u_digit (
      .hex   (hex_ff),
      .mag   (mag_ff),
      .digit (digit),
      .quot  (quot)
   );

   // cell 0 faces the output; pushes enter there and pops leave there
   for (genvar k = 0; k < NC; k++) begin : g_chain
      n7s_pkg::code_type lo_code;
      n7s_pkg::code_type hi_code;
      if (k == 0) begin : g_lo_end
         assign lo_code = new_code;
      end else begin : g_lo_mid
         assign lo_code = cell_code[k-1];
      end
      if (k == NC - 1) begin : g_hi_end
         assign hi_code = n7s_pkg::CODE_BLANK;
      end else begin : g_hi_mid
         assign hi_code = cell_code[k+1];
      end
      n7s_cell u_cell (
         .clock   (clock),
         .ctl     (ctl),
         .lo_code (lo_code),
         .hi_code (hi_code),
         .code    (cell_code[k])
      );
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign req_take  = req_valid && req_ready;
   assign emit_load = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      if (digit_count_ff == 4'd0) begin
         n_sat = 4'd1;
      end else if (digit_count_ff > 4'(NC)) begin
         n_sat = 4'(NC);
      end else begin
         n_sat = digit_count_ff;
      end
      n_m1     = PW'(n_sat - 4'd1);
      roff_sat = (req_right_offset > n_m1) ? n_m1 : req_right_offset;
   end

   // character for the current place, right to left
   always_comb begin
      new_code     = n7s_pkg::CODE_BLANK;
      sign_done_in = sign_done_ff;
      if (mag_ff != 32'd0 || first_ff) begin
         new_code = {1'b0, digit};
      end else if (lz_ff) begin
         new_code = (neg_ff && step_ff == top_ff) ? n7s_pkg::CODE_MINUS
                                                  : n7s_pkg::CODE_ZERO;
      end else if (neg_ff && !sign_done_ff) begin
         new_code     = n7s_pkg::CODE_MINUS;
         sign_done_in = 1'b1;
      end
      if (state_ff != ST_CONV) begin
         sign_done_in = 1'b0;
      end
   end

   always_comb begin
      state_in      = state_ff;
      mag_in        = mag_ff;
      hex_in        = hex_ff;
      lz_in         = lz_ff;
      neg_in        = neg_ff;
      first_in      = first_ff;
      dots_in       = dots_ff;
      module_in     = module_ff;
      step_in       = step_ff;
      top_in        = top_ff;
      place_in      = place_ff;
      last_place_in = last_place_ff;
      ctl           = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && ({1'b0, req_module_req} < unit_limit_ff)) begin
               neg_in        = req_number[31];
               mag_in        = req_number[31] ? (32'd0 - req_number) : req_number;
               hex_in        = req_mode;
               lz_in         = req_leading_zeros;
               first_in      = 1'b1;
               dots_in       = req_dot_mask;
               module_in     = req_module_req;
               step_in       = '0;
               top_in        = n_m1 - roff_sat;
               last_place_in = n_m1;
               ctl.clear     = 1'b1;
               state_in      = ST_CONV;
            end
         end
         ST_CONV: begin
            ctl.push = 1'b1;
            mag_in   = quot;
            first_in = 1'b0;
            if (step_ff == top_ff) begin
               place_in = last_place_ff;
               state_in = ST_EMIT;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (emit_load) begin
               ctl.pop = 1'b1;
               dots_in = {dots_ff[6:0], 1'b0};
               if (place_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  place_in = place_ff - 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      seg            = n7s_pkg::glyph(cell_code[0]);
      rsp_module_in  = rsp_module_ff;
      rsp_place_in   = rsp_place_ff;
      rsp_pattern_in = rsp_pattern_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_valid_in   = rsp_valid_ff;
      if (emit_load) begin
         rsp_valid_in   = 1'b1;
         rsp_module_in  = module_ff;
         rsp_place_in   = place_ff;
         rsp_last_in    = (place_ff == '0);
         rsp_pattern_in = segment_order_ff ? {seg, dots_ff[7]} : {dots_ff[7], seg};
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         rsp_valid_ff     <= 1'b0;
         sign_done_ff     <= 1'b0;
         digit_count_ff   <= 4'd8;
         unit_limit_ff    <= 4'd1;
         segment_order_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sign_done_ff <= sign_done_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               n7s_pkg::CSR_DIGIT_COUNT:   digit_count_ff   <= csr_data;
               n7s_pkg::CSR_UNIT_LIMIT:    unit_limit_ff    <= csr_data;
               n7s_pkg::CSR_SEGMENT_ORDER: segment_order_ff <= csr_data[0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      mag_ff         <= mag_in;
      hex_ff         <= hex_in;
      lz_ff          <= lz_in;
      neg_ff         <= neg_in;
      first_ff       <= first_in;
      dots_ff        <= dots_in;
      module_ff      <= module_in;
      step_ff        <= step_in;
      top_ff         <= top_in;
      place_ff       <= place_in;
      last_place_ff  <= last_place_in;
      rsp_module_ff  <= rsp_module_in;
      rsp_place_ff   <= rsp_place_in;
      rsp_pattern_ff <= rsp_pattern_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_target_module   = rsp_module_ff;
   assign rsp_digit_position  = rsp_place_ff;
   assign rsp_segment_pattern = rsp_pattern_ff;
   assign rsp_last            = rsp_last_ff;

endmodule

@@ tb/sv/number_to_seven_segment_formatter_tb.sv @@
`timescale 1ns / 1ps
module number_to_seven_segment_formatter_tb;

   localparam int SETTLE_CYCLES = 40;
   localparam int RANDOM_PHASES = 5;
   localparam int PHASE_ITEMS = 16;

   typedef struct packed {
      logic [2:0] target_module;
      logic [2:0] digit_position;
      logic [7:0] segment_pattern;
      logic       last;
   } pattern_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_number = '0;
   logic        req_mode = 1'b0;
   logic [7:0]  req_dot_mask = '0;
   logic        req_leading_zeros = 1'b0;
   logic [2:0]  req_right_offset = '0;
   logic [2:0]  req_module_req = '0;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_target_module;
   logic [2:0]  rsp_digit_position;
   logic [7:0]  rsp_segment_pattern;
   logic        rsp_last;

   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [3:0]  csr_data = '0;

   // shadow of the block's registers, updated when a csr write is taken
   logic [3:0]  digit_count_q = 4'd8;
   logic [3:0]  unit_limit_q = 4'd1;
   logic        segment_order_q = 1'b0;

   pattern_type pending_patterns[$];
   int unsigned fail_count = 0;
   int unsigned numbers_sent = 0;
   int unsigned patterns_checked = 0;
   int unsigned csr_writes = 0;
   bit          calm = 1'b0;
   int unsigned stall_left = 0;

   number_to_seven_segment_formatter u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_number          (req_number),
      .req_mode            (req_mode),
      .req_dot_mask        (req_dot_mask),
      .req_leading_zeros   (req_leading_zeros),
      .req_right_offset    (req_right_offset),
      .req_module_req      (req_module_req),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_target_module   (rsp_target_module),
      .rsp_digit_position  (rsp_digit_position),
      .rsp_segment_pattern (rsp_segment_pattern),
      .rsp_last            (rsp_last),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #2000000;
      $display("timeout at %0t", $time);
      $display("Some tests failed");
      $finish;
   end

   function automatic logic [6:0] shape_of(input n7s_pkg::code_type code);
      logic [6:0] seg;
      case (code)
         5'd0:                seg = 7'h7E;
         5'd1:                seg = 7'h30;
         5'd2:                seg = 7'h6D;
         5'd3:                seg = 7'h79;
         5'd4:                seg = 7'h33;
         5'd5:                seg = 7'h5B;
         5'd6:                seg = 7'h5F;
         5'd7:                seg = 7'h70;
         5'd8:                seg = 7'h7F;
         5'd9:                seg = 7'h7B;
         5'd10:               seg = 7'h77;
         5'd11:               seg = 7'h7F;
         5'd12:               seg = 7'h4E;
         5'd13:               seg = 7'h7E;
         5'd14:               seg = 7'h4F;
         5'd15:               seg = 7'h47;
         n7s_pkg::CODE_MINUS: seg = 7'h01;
         default:             seg = 7'h00;
      endcase
      return seg;
   endfunction

   // expected patterns for one number, leftmost place first
   function automatic void format_number(input logic [31:0] value, input logic hex_mode,
                                         input logic [7:0] dots, input logic lz,
                                         input logic [2:0] offset, input logic [2:0] module_idx);
      int unsigned       places;
      int unsigned       shift;
      int unsigned       top_place;
      int unsigned       p;
      int unsigned       d;
      logic              neg;
      logic              done;
      logic [31:0]       mag;
      logic [31:0]       digit;
      n7s_pkg::code_type codes [0:7];
      pattern_type       item;
      logic [6:0]        seg;
      logic              dp;
      if ({1'b0, module_idx} >= unit_limit_q)
         return;
      places = 32'(digit_count_q);
      if (places < 1)
         places = 1;
      if (places > n7s_pkg::PLACE_CAP)
         places = n7s_pkg::PLACE_CAP;
      shift = (32'(offset) > places - 1) ? places - 1 : 32'(offset);
      top_place = places - 1 - shift;
      neg = value[31];
      mag = neg ? (32'd0 - value) : value;
      for (d = 0; d < 8; d++)
         codes[3'(d)] = n7s_pkg::CODE_BLANK;
      if (mag == 0) begin
         if (lz) begin
            for (d = 0; d < top_place; d++)
               codes[3'(d)] = n7s_pkg::CODE_ZERO;
         end
         codes[3'(top_place)] = n7s_pkg::CODE_ZERO;
      end else begin
         p = top_place;
         done = 1'b0;
         while (!done) begin
            if (mag == 0) begin
               if (lz) begin
                  codes[3'(p)] = n7s_pkg::CODE_ZERO;
                  // with zero fill the sign only fits the leftmost place
                  if (neg && p == 0)
                     codes[0] = n7s_pkg::CODE_MINUS;
               end else begin
                  if (neg)
                     codes[3'(p)] = n7s_pkg::CODE_MINUS;
                  done = 1'b1;
               end
            end else begin
               digit = hex_mode ? {28'd0, mag[3:0]} : mag % 32'd10;
               codes[3'(p)] = digit[4:0];
            end
            if (!done) begin
               mag = hex_mode ? (mag >> 4) : (mag / 32'd10);
               if (p == 0)
                  done = 1'b1;
               else
                  p--;
            end
         end
      end
      for (d = 0; d < places; d++) begin
         seg = shape_of(codes[3'(d)]);
         dp = dots[3'(7 - d)];
         item.target_module = module_idx;
         item.digit_position = 3'(places - 1 - d);
         item.segment_pattern = segment_order_q ? {seg, dp} : {dp, seg};
         item.last = (places - 1 - d) == 0;
         pending_patterns.push_back(item);
      end
   endfunction

   task automatic note_mismatch(input string field, input int unsigned want,
                                input int unsigned got);
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      fail_count++;
   endtask

   always @(posedge clock) begin : rsp_check
      pattern_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_patterns.size() == 0) begin
            $display("%0t: unexpected pattern, expected none, actual module %0d place %0d seg %h",
                     $time, rsp_target_module, rsp_digit_position, rsp_segment_pattern);
            fail_count++;
         end else begin
            want = pending_patterns.pop_front();
            patterns_checked++;
            if (rsp_target_module !== want.target_module)
               note_mismatch("target_module", 32'(want.target_module),
                             32'(rsp_target_module));
            if (rsp_digit_position !== want.digit_position)
               note_mismatch("digit_position", 32'(want.digit_position),
                             32'(rsp_digit_position));
            if (rsp_segment_pattern !== want.segment_pattern)
               note_mismatch("segment_pattern", 32'(want.segment_pattern),
                             32'(rsp_segment_pattern));
            if (rsp_last !== want.last)
               note_mismatch("last", 32'(want.last), 32'(rsp_last));
         end
      end
   end

   // receiver back-pressure in short random bursts
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
         rsp_ready <= 1'b0;
         stall_left <= $urandom_range(0, 2);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // called at a clock edge; returns at the edge that takes the transaction
   task automatic send_number(input logic [31:0] value, input logic hex_mode,
                              input logic [7:0] dots, input logic lz,
                              input logic [2:0] offset, input logic [2:0] module_idx);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_number <= value;
      req_mode <= hex_mode;
      req_dot_mask <= dots;
      req_leading_zeros <= lz;
      req_right_offset <= offset;
      req_module_req <= module_idx;
      do
         @(posedge clock);
      while (!req_ready);
      format_number(value, hex_mode, dots, lz, offset, module_idx);
      numbers_sent++;
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_patterns.size() != 0)
         @(posedge clock);
   endtask

   // a request to an ignored module can still be in flight after the drain
   task automatic settle;
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [3:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do
         @(posedge clock);
      while (!csr_ready);
      case (idx)
         n7s_pkg::CSR_DIGIT_COUNT:   digit_count_q = value;
         n7s_pkg::CSR_UNIT_LIMIT:    unit_limit_q = value;
         n7s_pkg::CSR_SEGMENT_ORDER: segment_order_q = value[0];
         default: ;
      endcase
      csr_writes++;
   endtask

   task automatic apply_config(input logic [3:0] places, input logic [3:0] units,
                               input logic [3:0] order);
      write_csr(n7s_pkg::CSR_DIGIT_COUNT, places);
      write_csr(n7s_pkg::CSR_UNIT_LIMIT, units);
      write_csr(n7s_pkg::CSR_SEGMENT_ORDER, order);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_power_on_format;
      send_number(32'd0, 1'b0, 8'h00, 1'b0, 3'd0, 3'd0);
      send_number(32'd0, 1'b1, 8'h01, 1'b1, 3'd0, 3'd0);
      send_number(-32'd1, 1'b0, 8'h80, 1'b0, 3'd0, 3'd0);
      // ten decimal digits on eight places: the top ones fall off
      send_number(32'h7FFF_FFFF, 1'b0, 8'hFF, 1'b0, 3'd0, 3'd0);
      send_number(32'h8000_0001, 1'b1, 8'h00, 1'b0, 3'd0, 3'd0);
      send_number(32'h8000_0000, 1'b1, 8'h00, 1'b1, 3'd0, 3'd0);
      send_number(32'h8000_0000, 1'b0, 8'h00, 1'b0, 3'd0, 3'd0);
      send_number(-32'd5, 1'b0, 8'h00, 1'b1, 3'd0, 3'd0);
      send_number(32'h00AB_CDEF, 1'b1, 8'h55, 1'b0, 3'd2, 3'd0);
      send_number(-32'd255, 1'b1, 8'h00, 1'b0, 3'd7, 3'd0);
      send_number(32'd12345, 1'b0, 8'hAA, 1'b1, 3'd3, 3'd0);
      send_number(32'd42, 1'b0, 8'h00, 1'b0, 3'd0, 3'd1);
      send_number(32'd42, 1'b0, 8'h00, 1'b0, 3'd0, 3'd7);
      settle();
   endtask

   task automatic test_short_display;
      apply_config(4'd1, 4'd8, 4'd0);
      send_number(-32'd7, 1'b0, 8'h80, 1'b0, 3'd5, 3'd3);
      send_number(32'h0000_000F, 1'b1, 8'h7F, 1'b1, 3'd0, 3'd0);
      settle();
      apply_config(4'd4, 4'd2, 4'd0);
      send_number(-32'd123, 1'b0, 8'h10, 1'b0, 3'd0, 3'd1);
      send_number(-32'd1234, 1'b0, 8'h00, 1'b0, 3'd0, 3'd0);
      send_number(-32'd12, 1'b0, 8'hF0, 1'b1, 3'd1, 3'd1);
      send_number(32'h0000_FFFF, 1'b1, 8'h00, 1'b0, 3'd0, 3'd2);
      settle();
   endtask

   task automatic test_segment_order_flip;
      // only bit 0 of the write counts for the order
      apply_config(4'd8, 4'd8, 4'hF);
      send_number(32'h89AB_CDEF, 1'b1, 8'hFF, 1'b0, 3'd0, 3'd7);
      send_number(32'd90210, 1'b0, 8'h81, 1'b1, 3'd1, 3'd4);
      settle();
      apply_config(4'd6, 4'd8, 4'hE);
      send_number(-32'd31337, 1'b0, 8'h24, 1'b0, 3'd0, 3'd5);
      settle();
   endtask

   task automatic test_place_count_limits;
      // no module is addressable: every transaction is swallowed
      apply_config(4'd0, 4'd0, 4'd0);
      send_number(32'd7, 1'b0, 8'h00, 1'b0, 3'd0, 3'd0);
      settle();
      apply_config(4'd15, 4'd15, 4'd1);
      send_number(32'hDEAD_BEEF, 1'b1, 8'hC3, 1'b1, 3'd6, 3'd7);
      send_number(-32'd9, 1'b0, 8'h00, 1'b1, 3'd0, 3'd6);
      settle();
      apply_config(4'd0, 4'd1, 4'd0);
      send_number(32'd86, 1'b0, 8'h80, 1'b0, 3'd2, 3'd0);
      settle();
   endtask

   function automatic logic [31:0] pick_number();
      logic [31:0] value;
      case ($urandom_range(0, 5))
         0: value = $urandom_range(0, 99);
         1: value = 32'd0 - 32'($urandom_range(1, 999));
         2: value = $urandom;
         3: begin
            case ($urandom_range(0, 3))
               0: value = 32'h8000_0000;
               1: value = 32'h8000_0001;
               2: value = 32'h7FFF_FFFF;
               default: value = 32'd0;
            endcase
         end
         4: value = $urandom >> $urandom_range(0, 31);
         default: value = 32'd0 - ($urandom >> $urandom_range(1, 31));
      endcase
      return value;
   endfunction

   task automatic test_random_mix;
      int unsigned phase;
      int unsigned k;
      logic [2:0]  module_idx;
      int unsigned reach;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: apply_config(4'd8, 4'($urandom_range(1, 8)), 4'($urandom_range(0, 15)));
            1: apply_config(4'd1, 4'($urandom_range(1, 8)), 4'($urandom_range(0, 15)));
            default: apply_config(4'($urandom_range(1, 8)), 4'($urandom_range(1, 8)),
                                  4'($urandom_range(0, 15)));
         endcase
         if (phase == RANDOM_PHASES - 1)
            calm = 1'b1;
         reach = (32'(unit_limit_q) > 8) ? 7 : 32'(unit_limit_q) - 1;
         for (k = 0; k < PHASE_ITEMS; k++) begin
            if ($urandom_range(0, 7) == 0)
               module_idx = 3'($urandom_range(0, 7));
            else
               module_idx = 3'($urandom_range(0, reach));
            send_number(pick_number(), 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), module_idx);
            // hold off until the display has caught up
            if (phase == 2 && k % 4 == 3)
               drain();
         end
         settle();
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_power_on_format();
      test_short_display();
      test_segment_order_flip();
      test_place_count_limits();
      test_random_mix();
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("sent %0d numbers, checked %0d segment patterns", numbers_sent,
               patterns_checked);
      $display("over %0d register writes, both bit orders, 1 to 8 places", csr_writes);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
